[src/button_debounce_press_classifier_unit_defines.svh]
// assertion macros used by the checker file
`ifndef BUTTON_DEBOUNCE_PRESS_CLASSIFIER_UNIT_DEFINES_SVH
`define BUTTON_DEBOUNCE_PRESS_CLASSIFIER_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define BDPC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define BDPC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/bdpc_pkg.sv]
package bdpc_pkg;

  // one poll of the pin
  typedef struct packed {
    logic        pin_level;
    logic [31:0] now_ms;
  } in_item_t;

  // one result per poll
  typedef struct packed {
    logic        event_valid;
    logic [15:0] event_message;
    logic        clean_level;
  } out_item_t;

  // configuration register set
  typedef struct packed {
    logic [15:0] code_base;
    logic        press_level;
    logic [15:0] long_ms;
    logic [15:0] very_long_ms;
  } cfg_t;

  localparam int CfgIndexWidth = 8;

  // register indexes
  localparam logic [CfgIndexWidth-1:0] REG_CODE_BASE    = 8'd0;
  localparam logic [CfgIndexWidth-1:0] REG_PRESS_LEVEL  = 8'd1;
  localparam logic [CfgIndexWidth-1:0] REG_LONG_MS      = 8'd2;
  localparam logic [CfgIndexWidth-1:0] REG_VERY_LONG_MS = 8'd3;

  // register reset values
  localparam logic [15:0] DEFAULT_CODE_BASE    = 16'd0;
  localparam logic        DEFAULT_PRESS_LEVEL  = 1'b1;
  localparam logic [15:0] DEFAULT_LONG_MS      = 16'd1200;
  localparam logic [15:0] DEFAULT_VERY_LONG_MS = 16'd2500;

  // hold phases
  localparam logic [1:0] PHASE_RELEASED  = 2'd0;
  localparam logic [1:0] PHASE_DOWN      = 2'd1;
  localparam logic [1:0] PHASE_LONG      = 2'd2;
  localparam logic [1:0] PHASE_VERY_LONG = 2'd3;

  // event codes, added to code_base
  localparam logic [2:0] CODE_DOWN           = 3'd0;
  localparam logic [2:0] CODE_LONG_DOWN      = 3'd1;
  localparam logic [2:0] CODE_VERY_LONG_DOWN = 3'd2;
  localparam logic [2:0] CODE_UP             = 3'd3;
  localparam logic [2:0] CODE_LONG_UP        = 3'd4;
  localparam logic [2:0] CODE_VERY_LONG_UP   = 3'd5;

endpackage

[src/bdpc_cfg.sv]
module bdpc_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               wr_en,
  input  logic [bdpc_pkg::CfgIndexWidth-1:0] wr_index,
  input  logic [15:0]                        wr_data,
  output bdpc_pkg::cfg_t                     cfg
);
  import bdpc_pkg::*;

  // register file, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.code_base    <= DEFAULT_CODE_BASE;
      cfg.press_level  <= DEFAULT_PRESS_LEVEL;
      cfg.long_ms      <= DEFAULT_LONG_MS;
      cfg.very_long_ms <= DEFAULT_VERY_LONG_MS;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_CODE_BASE:    cfg.code_base    <= wr_data;
        REG_PRESS_LEVEL:  cfg.press_level  <= wr_data[0];
        REG_LONG_MS:      cfg.long_ms      <= wr_data;
        REG_VERY_LONG_MS: cfg.very_long_ms <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

[src/bdpc_core.sv]
module bdpc_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  bdpc_pkg::in_item_t  item,
  input  bdpc_pkg::cfg_t      cfg,
  output bdpc_pkg::out_item_t result
);
  import bdpc_pkg::*;

  logic [1:0]  history;
  logic        stable_level;
  logic [1:0]  phase;
  logic [31:0] press_stamp;

  logic [1:0]  history_next;
  logic        stable_level_next;
  logic [1:0]  phase_next;
  logic [31:0] press_stamp_next;

  logic        ev;
  logic [2:0]  code;
  logic [31:0] elapsed;

  // debounce, press/release and hold promotion for one poll
  always_comb begin
    history_next      = {history[0], item.pin_level};
    stable_level_next = (history[1] == item.pin_level) ? history[1] : stable_level;
    phase_next        = phase;
    press_stamp_next  = press_stamp;
    ev                = 1'b0;
    code              = CODE_DOWN;
    elapsed           = item.now_ms - press_stamp;

    if (stable_level_next != stable_level) begin
      if (stable_level_next != cfg.press_level) begin
        // release, silent if never pressed
        unique case (phase)
          PHASE_DOWN: begin
            ev   = 1'b1;
            code = CODE_UP;
          end
          PHASE_LONG: begin
            ev   = 1'b1;
            code = CODE_LONG_UP;
          end
          PHASE_VERY_LONG: begin
            ev   = 1'b1;
            code = CODE_VERY_LONG_UP;
          end
          default: ;
        endcase
        phase_next = PHASE_RELEASED;
      end else begin
        // press
        press_stamp_next = item.now_ms;
        phase_next       = PHASE_DOWN;
        ev               = 1'b1;
        code             = CODE_DOWN;
      end
    end else if (stable_level == cfg.press_level) begin
      // held: one promotion step at most
      if (phase == PHASE_DOWN && elapsed >= {16'd0, cfg.long_ms}) begin
        phase_next = PHASE_LONG;
        ev         = 1'b1;
        code       = CODE_LONG_DOWN;
      end else if (phase == PHASE_LONG && elapsed >= {16'd0, cfg.very_long_ms}) begin
        phase_next = PHASE_VERY_LONG;
        ev         = 1'b1;
        code       = CODE_VERY_LONG_DOWN;
      end
    end

    result.event_valid   = ev;
    result.event_message = ev ? (cfg.code_base + {13'd0, code}) : 16'd0;
    result.clean_level   = stable_level_next;
  end

  // poll state
  always_ff @(posedge clk) begin
    if (rst) begin
      history      <= 2'b00;
      stable_level <= 1'b0;
      phase        <= PHASE_RELEASED;
      press_stamp  <= 32'd0;
    end else if (step) begin
      history      <= history_next;
      stable_level <= stable_level_next;
      phase        <= phase_next;
      press_stamp  <= press_stamp_next;
    end
  end

endmodule

[src/button_debounce_press_classifier_unit.sv]
// a result becomes valid after passing the input register and then the result register
// one poll per cycle while the result side is not stalled
// a stalled result holds back the input register only, never a finished result
// reset (rst, synchronous): clears pipeline valids and debounce state,
// and loads the configuration registers with their defaults
module button_debounce_press_classifier_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  bdpc_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output bdpc_pkg::out_item_t                out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bdpc_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [15:0]                        cfg_data
);
  import bdpc_pkg::*;

  cfg_t      cfg;
  logic      s1_valid;
  in_item_t  s1_item;
  logic      advance;
  out_item_t result;

  // configuration port never blocks
  assign cfg_ready = 1'b1;

  bdpc_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // flow control
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_item <= in_data;
    end
  end

  bdpc_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (s1_item),
    .cfg    (cfg),
    .result (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

endmodule

[src/bdpc_checker.sv]
`include "button_debounce_press_classifier_unit_defines.svh"

module bdpc_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input bdpc_pkg::out_item_t                out_data,
  input logic                               cfg_valid,
  input logic                               cfg_ready,
  input logic [bdpc_pkg::CfgIndexWidth-1:0] cfg_index,
  input logic [15:0]                        cfg_data
);
  import bdpc_pkg::*;

  logic [15:0] base_seen;
  logic [15:0] msg_offset;

  // shadow of the code base as written through the port
  always_ff @(posedge clk) begin
    if (rst) begin
      base_seen <= DEFAULT_CODE_BASE;
    end else if (cfg_valid && cfg_ready && cfg_index == REG_CODE_BASE) begin
      base_seen <= cfg_data;
    end
  end

  assign msg_offset = out_data.event_message - base_seen;

  // a result waiting on stall stays put
  `BDPC_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_data), "result changed while stalled")
  // input only backs up behind a stalled result
  `BDPC_ASSERT_NOW(a_stall_cause, clk, rst, in_stall, out_valid && out_stall, "input stalled without output stall")
  // no event means a zero message
  `BDPC_ASSERT_NOW(a_quiet_msg, clk, rst, out_valid && !out_data.event_valid, out_data.event_message == 16'd0, "message without event")
  // event code is one of the six defined
  `BDPC_ASSERT_NOW(a_code_range, clk, rst, out_valid && out_data.event_valid, msg_offset <= {13'd0, CODE_VERY_LONG_UP}, "event code out of range")

endmodule

bind button_debounce_press_classifier_unit bdpc_checker u_checker (.*);

[test/button_debounce_press_classifier_unit_test.sv]
`timescale 1ns / 100ps

module button_debounce_press_classifier_unit_test;
  import bdpc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned MISMATCH_PRINT_LIMIT = 100;

  // indexes with no register behind them
  localparam logic [CfgIndexWidth-1:0] UNMAPPED_REG_LOW  = 8'd4;
  localparam logic [CfgIndexWidth-1:0] UNMAPPED_REG_HIGH = 8'hFF;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  in_item_t                 in_data = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  out_item_t                out_data;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CfgIndexWidth-1:0] cfg_index = '0;
  logic [15:0]              cfg_data = '0;

  // register values the block should hold
  cfg_t reg_mirror = '{DEFAULT_CODE_BASE, DEFAULT_PRESS_LEVEL,
                       DEFAULT_LONG_MS, DEFAULT_VERY_LONG_MS};

  // debounce and hold tracking of the block
  logic [1:0]  sample_pair = 2'b00;
  logic        debounced = 1'b0;
  logic        shown_level = 1'b0;
  logic [1:0]  hold_state = PHASE_RELEASED;
  logic [31:0] press_time = '0;

  out_item_t   expected_results[$];
  logic [31:0] clock_ms = '0;
  int unsigned send_gap_max = 5;
  int unsigned recv_wait_max = 5;
  int unsigned hold_off_cycles = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  button_debounce_press_classifier_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < MISMATCH_PRINT_LIMIT)
      $display("%0t mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // debounce one poll, update the hold phase and build the event
  function automatic out_item_t classify_poll(input in_item_t poll);
    logic        oldest;
    logic        settled;
    logic        raised;
    logic [2:0]  code;
    logic [31:0] held_ms;
    out_item_t   result;
    oldest = sample_pair[1];
    sample_pair = {sample_pair[0], poll.pin_level};
    settled = (oldest == poll.pin_level) ? oldest : debounced;
    raised = 1'b0;
    code = CODE_DOWN;
    if (settled != debounced) begin
      shown_level = settled;
      if (settled != reg_mirror.press_level) begin
        // release: nothing to report when no press was being held
        case (hold_state)
          PHASE_DOWN: begin
            raised = 1'b1;
            code = CODE_UP;
          end
          PHASE_LONG: begin
            raised = 1'b1;
            code = CODE_LONG_UP;
          end
          PHASE_VERY_LONG: begin
            raised = 1'b1;
            code = CODE_VERY_LONG_UP;
          end
          default: ;
        endcase
        hold_state = PHASE_RELEASED;
      end else begin
        press_time = poll.now_ms;
        hold_state = PHASE_DOWN;
        raised = 1'b1;
        code = CODE_DOWN;
      end
      debounced = settled;
    end
    // promotions only on polls that raised nothing else
    held_ms = poll.now_ms - press_time;
    if (!raised && shown_level == reg_mirror.press_level) begin
      if (hold_state == PHASE_DOWN && held_ms >= 32'(reg_mirror.long_ms)) begin
        hold_state = PHASE_LONG;
        raised = 1'b1;
        code = CODE_LONG_DOWN;
      end else if (hold_state == PHASE_LONG &&
                   held_ms >= 32'(reg_mirror.very_long_ms)) begin
        hold_state = PHASE_VERY_LONG;
        raised = 1'b1;
        code = CODE_VERY_LONG_DOWN;
      end
    end
    result.event_valid = raised;
    result.event_message = raised ? reg_mirror.code_base + 16'(code) : 16'd0;
    result.clean_level = shown_level;
    return result;
  endfunction

  // predict on each input transfer, check each output transfer
  always @(posedge clk) begin : poll_checker
    out_item_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with none expected", 32'd1, 32'd0);
        end else begin
          want = expected_results.pop_front();
          if (out_data.event_valid !== want.event_valid)
            report_mismatch("event_valid", 32'(out_data.event_valid), 32'(want.event_valid));
          if (out_data.event_message !== want.event_message)
            report_mismatch("event_message", 32'(out_data.event_message),
                            32'(want.event_message));
          if (out_data.clean_level !== want.clean_level)
            report_mismatch("clean_level", 32'(out_data.clean_level), 32'(want.clean_level));
        end
      end
      if (in_valid && !in_stall)
        expected_results.push_back(classify_poll(in_data));
    end
  end

  // result side: random stalls, plus a long hold-off when one is requested
  initial begin : result_sink
    int unsigned wait_cycles;
    while (rst) @(posedge clk);
    forever begin
      if (hold_off_cycles != 0) begin
        wait_cycles = hold_off_cycles;
        hold_off_cycles = 0;
      end else begin
        wait_cycles = (recv_wait_max == 0) ? 0 : $urandom_range(0, recv_wait_max);
      end
      if (wait_cycles != 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_poll(input in_item_t poll);
    int unsigned gap;
    gap = (send_gap_max == 0) ? 0 : $urandom_range(0, send_gap_max);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= poll;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic poll_pin(input logic pin, input logic [31:0] step_ms);
    clock_ms += step_ms;
    send_poll('{pin_level: pin, now_ms: clock_ms});
  endtask

  // stop sending and let every pending result come back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_register(input logic [CfgIndexWidth-1:0] index,
                                input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (index)
      REG_CODE_BASE:    reg_mirror.code_base = value;
      REG_PRESS_LEVEL:  reg_mirror.press_level = value[0];
      REG_LONG_MS:      reg_mirror.long_ms = value;
      REG_VERY_LONG_MS: reg_mirror.very_long_ms = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // a held press followed by a release, with occasional contact bounce
  task automatic press_sequence(input logic pressed, input int unsigned hold_polls,
                                input int unsigned release_polls,
                                input logic [31:0] step_max);
    repeat (hold_polls)
      poll_pin(pressed ^ ($urandom_range(0, 9) == 0), $urandom_range(0, step_max));
    repeat (release_polls)
      poll_pin(~pressed ^ ($urandom_range(0, 9) == 0), $urandom_range(0, step_max / 8 + 1));
  endtask

  function automatic logic [15:0] draw_threshold();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(1, 60));
      3: return 16'($urandom);
      default: return 16'($urandom_range(0, 3000));
    endcase
  endfunction

  task automatic test_default_press();
    // timestamps at both ends of the range
    clock_ms = 32'hFFFF_FFFE;
    poll_pin(1'b0, 32'd1);
    poll_pin(1'b0, 32'd1);
    // short press and release
    repeat (3) poll_pin(1'b1, 32'd10);
    repeat (3) poll_pin(1'b0, 32'd10);
    // hold across the timestamp wrap, promotions exactly at the thresholds
    clock_ms = 32'hFFFF_FC00;
    repeat (3) poll_pin(1'b1, 32'd0);
    poll_pin(1'b1, 32'd1200);
    poll_pin(1'b1, 32'd1300);
    repeat (3) poll_pin(1'b0, 32'd5);
  endtask

  task automatic test_register_extremes();
    wait_for_results();
    write_register(REG_CODE_BASE, 16'hFFFF);
    write_register(REG_LONG_MS, 16'd0);
    write_register(REG_VERY_LONG_MS, 16'd0);
    // zero thresholds: the press poll raises only the press, promotions follow
    repeat (5) poll_pin(1'b1, 32'd0);
    repeat (3) poll_pin(1'b0, 32'd0);
    wait_for_results();
    write_register(REG_LONG_MS, 16'hFFFF);
    write_register(REG_VERY_LONG_MS, 16'hFFFF);
    repeat (3) poll_pin(1'b1, 32'd0);
    repeat (2) poll_pin(1'b1, 32'd32768);
    repeat (3) poll_pin(1'b0, 32'd1);
    // unmapped writes are dropped, press level takes bit 0 only
    wait_for_results();
    write_register(UNMAPPED_REG_LOW, 16'h1234);
    write_register(UNMAPPED_REG_HIGH, 16'hFFFF);
    write_register(REG_PRESS_LEVEL, 16'hFFFE);
    // going high is now a release with nothing held
    repeat (3) poll_pin(1'b1, 32'd5);
    repeat (3) poll_pin(1'b0, 32'd5);
    wait_for_results();
    write_register(REG_PRESS_LEVEL, 16'd1);
    write_register(REG_CODE_BASE, 16'd0);
    write_register(REG_LONG_MS, 16'd40);
    write_register(REG_VERY_LONG_MS, 16'd90);
  endtask

  task automatic test_backpressure();
    wait_for_results();
    send_gap_max = 0;
    recv_wait_max = 0;
    // receiver holds off while polls keep coming back to back
    hold_off_cycles = 60;
    press_sequence(reg_mirror.press_level, 12, 6, 32'd30);
    press_sequence(reg_mirror.press_level, 8, 4, 32'd30);
    // sender pauses until everything is back, then a second hold-off
    wait_for_results();
    send_gap_max = 2;
    hold_off_cycles = 40;
    press_sequence(reg_mirror.press_level, 10, 5, 32'd30);
    send_gap_max = 5;
    recv_wait_max = 5;
  endtask

  task automatic test_random_presses();
    int unsigned polls;
    int unsigned burst;
    logic [15:0] longest;
    logic [31:0] step_max;
    logic        pressed;
    for (int round = 0; round < 6; round++) begin
      wait_for_results();
      case ($urandom_range(0, 3))
        0: write_register(REG_CODE_BASE, 16'd0);
        1: write_register(REG_CODE_BASE, 16'hFFFF);
        default: write_register(REG_CODE_BASE, 16'($urandom));
      endcase
      write_register(REG_PRESS_LEVEL, 16'($urandom));
      write_register(REG_LONG_MS, draw_threshold());
      write_register(REG_VERY_LONG_MS, draw_threshold());
      send_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 5;
      recv_wait_max = ($urandom_range(0, 2) == 0) ? 0 : 5;
      longest = (reg_mirror.long_ms > reg_mirror.very_long_ms) ?
                reg_mirror.long_ms : reg_mirror.very_long_ms;
      step_max = 32'(longest) / 4 + 4;
      polls = 0;
      while (polls < 70) begin
        if ($urandom_range(0, 5) == 0) begin
          // noise: random pin at random timestamps
          burst = $urandom_range(1, 6);
          repeat (burst) begin
            clock_ms = $urandom();
            poll_pin(1'($urandom_range(0, 1)), 32'd0);
          end
          polls += burst;
        end else begin
          pressed = ($urandom_range(0, 9) == 0) ? ~reg_mirror.press_level
                                                : reg_mirror.press_level;
          burst = $urandom_range(3, 14);
          polls += burst;
          press_sequence(pressed, burst, 3 + (polls - burst) % 4, step_max);
          polls += 3 + (polls - burst) % 4;
        end
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_default_press();
    test_register_extremes();
    test_backpressure();
    test_random_presses();
    wait_for_results();
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
